[design/footprint_overlap_resolver_core_assert.svh]
// Assertion macros shared by the footprint overlap resolver checkers.
// Depends on nothing; included by the checker file only.
`ifndef FOOTPRINT_OVERLAP_RESOLVER_CORE_ASSERT_SVH
`define FOOTPRINT_OVERLAP_RESOLVER_CORE_ASSERT_SVH

// Clocked assertion, quiet while reset is high.
`define FPOR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define FPOR_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/fpor_pkg.sv]
// Footprint overlap resolver package: field widths, codes and state type.
// No dependencies; used by the channel interfaces, the core and the checker.
`default_nettype none

package fpor_pkg;

   localparam int MODE_W     = 2;
   localparam int POS_W      = 16;
   localparam int FOOT_W     = 8;
   localparam int QIDX_W     = 10;
   localparam int STATUS_W   = 3;
   localparam int FNUM_W     = 10;
   localparam int COUNT_W    = 11;
   localparam int GRID_REG_W = 9;
   localparam int CSR_IDX_W  = 1;

   // Running totals stop here.
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 11'd1024;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_PLACE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_PLACED     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_BOUNDS = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BLOCKED    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_DONE       = 3'd4;

   // CSR register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HIGH = 1'd1;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_PLACE_CHECK,
      ST_WALK_READ,
      ST_WALK_OWN,
      ST_WALK_DECIDE,
      ST_PLACE_END,
      ST_QUERY_READ,
      ST_QUERY_USE,
      ST_FINISH
   } fpor_state_type;

endpackage

`default_nettype wire

[design/fpor_if.sv]
// Request and response channel interfaces (valid/ready plus payload).
// Depends on fpor_pkg for field widths.
`default_nettype none

interface fpor_req_if;
   import fpor_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic [FOOT_W-1:0]        foot_wide;
   logic [FOOT_W-1:0]        foot_high;
   logic                     unbreakable;
   logic [QIDX_W-1:0]        query_index;

   modport source (output valid, mode, pos_x, pos_y, foot_wide, foot_high, unbreakable,
                   query_index, input ready);
   modport sink (input valid, mode, pos_x, pos_y, foot_wide, foot_high, unbreakable,
                 query_index, output ready);
endinterface

interface fpor_rsp_if;
   import fpor_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [FNUM_W-1:0]     feature_number;
   logic [COUNT_W-1:0]    replaced_now;
   logic                  is_alive;
   logic [COUNT_W-1:0]    dropped_total;
   logic [COUNT_W-1:0]    replaced_total;

   modport source (output valid, status, feature_number, replaced_now, is_alive,
                   dropped_total, replaced_total, input ready);
   modport sink (input valid, status, feature_number, replaced_now, is_alive,
                 dropped_total, replaced_total, output ready);
endinterface

`default_nettype wire

[design/footprint_overlap_resolver_core.sv]
// Footprint overlap resolver core. Depends on fpor_pkg and fpor_if.
// Place inside grid: check, then a cell walk that stops at a live unbreakable owner, then the end step;
//   out of bounds or table full: check only; query: read then use; unused mode: straight to response; clear: sweep.
// One word in flight; the cell walk (one owner-memory read and one feature read per cell)
//   sets the place rate. Next word is taken the cycle after the response is loaded.
// Reset (synchronous, active high) clears control state, then sweeps the cell and alive memories
//   over max(GRID_SIDE^2, MAX_FEATURES) addresses with req ready low; CSR writes are taken meanwhile.
`default_nettype none

module footprint_overlap_resolver_core #(
   parameter int GRID_SIDE    = 256,
   parameter int MAX_FEATURES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   fpor_req_if.sink                             req_ch,
   fpor_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [fpor_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fpor_pkg::GRID_REG_W-1:0]      csr_wdata
);
   import fpor_pkg::*;

   // ---------------------------------------------------------------------------------------
   // Derived sizes
   // ---------------------------------------------------------------------------------------
   localparam int CELL_N  = GRID_SIDE * GRID_SIDE;
   localparam int CELL_W  = (CELL_N > 1) ? $clog2(CELL_N) : 1;
   localparam int FIDX_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int NUM_W   = $clog2(MAX_FEATURES + 1);
   localparam int CELL_DW = FIDX_W + 1;              // claimed bit + owner number
   localparam int SWEEP_N = (CELL_N > MAX_FEATURES) ? CELL_N : MAX_FEATURES;
   localparam int SW_W    = (SWEEP_N > 1) ? $clog2(SWEEP_N) : 1;
   localparam int EXT_W   = 17;                      // room for origin + size compares

   localparam logic [EXT_W-1:0]  SIDE_EXT   = EXT_W'(GRID_SIDE);
   localparam logic [CELL_W-1:0] ROW_STEP   = CELL_W'(GRID_SIDE);
   localparam logic [SW_W:0]     CELL_N_S   = (SW_W + 1)'(CELL_N);
   localparam logic [SW_W:0]     FEAT_N_S   = (SW_W + 1)'(MAX_FEATURES);
   localparam logic [SW_W-1:0]   SWEEP_LAST = SW_W'(SWEEP_N - 1);
   localparam logic [NUM_W-1:0]  NUM_LIMIT  = NUM_W'(MAX_FEATURES);
   localparam logic [EXT_W-1:0]  FEAT_EXT   = EXT_W'(MAX_FEATURES);

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v >= COUNT_LIMIT) ? COUNT_LIMIT : v + 11'd1;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------------
   fpor_state_type            state_ff, state_in;

   logic [GRID_REG_W-1:0]     grid_wide_ff, grid_wide_in;
   logic [GRID_REG_W-1:0]     grid_high_ff, grid_high_in;

   // captured request word
   logic signed [POS_W-1:0]   pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0]   pos_y_ff, pos_y_in;
   logic [FOOT_W-1:0]         foot_wide_ff, foot_wide_in;
   logic [FOOT_W-1:0]         foot_high_ff, foot_high_in;
   logic                      unbr_ff, unbr_in;
   logic [QIDX_W-1:0]         query_ff, query_in;

   // block state
   logic [NUM_W-1:0]          next_num_ff, next_num_in;
   logic [COUNT_W-1:0]        drop_cnt_ff, drop_cnt_in;
   logic [COUNT_W-1:0]        repl_cnt_ff, repl_cnt_in;

   // walk state
   logic [FIDX_W-1:0]         me_ff, me_in;
   logic                      me_alive_ff, me_alive_in;
   logic [COUNT_W-1:0]        killed_ff, killed_in;
   logic [FOOT_W-1:0]         dx_ff, dx_in;
   logic [FOOT_W-1:0]         dy_ff, dy_in;
   logic [CELL_W-1:0]         row_base_ff, row_base_in;

   // memory sweep
   logic [SW_W-1:0]           sweep_ff, sweep_in;
   logic                      sweep_reply_ff, sweep_reply_in;

   // result staging
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [FNUM_W-1:0]         res_num_ff, res_num_in;
   logic                      res_alive_ff, res_alive_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [FNUM_W-1:0]         rsp_num_ff, rsp_num_in;
   logic [COUNT_W-1:0]        rsp_killed_ff, rsp_killed_in;
   logic                      rsp_alive_ff, rsp_alive_in;
   logic [COUNT_W-1:0]        rsp_drop_ff, rsp_drop_in;
   logic [COUNT_W-1:0]        rsp_repl_ff, rsp_repl_in;

   // ---------------------------------------------------------------------------------------
   // Memories: cell owners, feature alive bits, feature unbreakable bits
   // ---------------------------------------------------------------------------------------
   logic [CELL_DW-1:0]        cell_mem [CELL_N];
   logic                      alive_mem [MAX_FEATURES];
   logic                      unbr_mem [MAX_FEATURES];

   logic [CELL_DW-1:0]        owner_rd_ff;
   logic                      alive_rd_ff;
   logic                      unbr_rd_ff;

   logic                      cell_we;
   logic [CELL_W-1:0]         cell_waddr;
   logic [CELL_DW-1:0]        cell_wdata;
   logic [CELL_W-1:0]         cell_raddr;

   logic                      alive_we;
   logic [FIDX_W-1:0]         alive_waddr;
   logic                      alive_wdata;
   logic                      unbr_we;
   logic [FIDX_W-1:0]         feat_raddr;

   // ---------------------------------------------------------------------------------------
   // Shared decode
   // ---------------------------------------------------------------------------------------
   logic [EXT_W-1:0]          grid_w_eff, grid_h_eff, x_end, y_end;
   logic                      out_of_bounds, table_full;
   logic [31:0]               row_start;
   logic [CELL_W-1:0]         cell_cur, cell_next;
   logic                      dx_last, dy_last;
   logic                      own_claimed;
   logic [FIDX_W-1:0]         own_idx;
   logic                      live_owner, hit_hard;
   logic                      sweep_last, rsp_free;
   logic [EXT_W-1:0]          me_ext, new_ext, query_ext;

   // Grid registers above GRID_SIDE act as GRID_SIDE.
   assign grid_w_eff = (EXT_W'(grid_wide_ff) > SIDE_EXT) ? SIDE_EXT : EXT_W'(grid_wide_ff);
   assign grid_h_eff = (EXT_W'(grid_high_ff) > SIDE_EXT) ? SIDE_EXT : EXT_W'(grid_high_ff);
   assign x_end      = {1'b0, pos_x_ff} + EXT_W'(foot_wide_ff);
   assign y_end      = {1'b0, pos_y_ff} + EXT_W'(foot_high_ff);

   assign out_of_bounds = pos_x_ff[POS_W-1] | pos_y_ff[POS_W-1] |
                          (foot_wide_ff == '0) | (foot_high_ff == '0) |
                          (x_end > grid_w_eff) | (y_end > grid_h_eff);
   assign table_full    = (next_num_ff >= NUM_LIMIT);

   // Linear address of the first cell; only used when the footprint is in bounds.
   assign row_start = (32'({1'b0, pos_y_ff}) * 32'(GRID_SIDE)) + 32'({1'b0, pos_x_ff});

   assign dx_last   = (dx_ff == foot_wide_ff - 8'd1);
   assign dy_last   = (dy_ff == foot_high_ff - 8'd1);
   assign cell_cur  = row_base_ff + CELL_W'(dx_ff);
   assign cell_next = dx_last ? (row_base_ff + ROW_STEP) : (cell_cur + 1'b1);

   assign own_claimed = owner_rd_ff[CELL_DW-1];
   assign own_idx     = owner_rd_ff[FIDX_W-1:0];
   // A live earlier owner of the cell just read; unbreakable ones stop the walk.
   assign live_owner  = own_claimed && (own_idx != me_ff) && alive_rd_ff;
   assign hit_hard    = live_owner && unbr_rd_ff;

   assign sweep_last = (sweep_ff == SWEEP_LAST);
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;

   assign me_ext    = EXT_W'(me_ff);
   assign new_ext   = EXT_W'(next_num_ff);
   assign query_ext = EXT_W'(query_ff);

   // ---------------------------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = sweep_reply_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               case (req_ch.mode)
                  MODE_PLACE: state_in = ST_PLACE_CHECK;
                  MODE_QUERY: state_in = ST_QUERY_READ;
                  MODE_CLEAR: state_in = ST_SWEEP;
                  default:    state_in = ST_FINISH;
               endcase
            end
         end
         ST_PLACE_CHECK: state_in = (table_full || out_of_bounds) ? ST_FINISH : ST_WALK_READ;
         ST_WALK_READ:   state_in = ST_WALK_OWN;
         ST_WALK_OWN:    state_in = ST_WALK_DECIDE;
         ST_WALK_DECIDE: begin
            if (hit_hard || (dx_last && dy_last)) begin
               state_in = ST_PLACE_END;
            end else begin
               state_in = ST_WALK_OWN;
            end
         end
         ST_PLACE_END:   state_in = ST_FINISH;
         ST_QUERY_READ:  state_in = ST_QUERY_USE;
         ST_QUERY_USE:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:        state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Datapath and memory controls
   // ---------------------------------------------------------------------------------------
   always_comb begin
      grid_wide_in   = grid_wide_ff;
      grid_high_in   = grid_high_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      foot_wide_in   = foot_wide_ff;
      foot_high_in   = foot_high_ff;
      unbr_in        = unbr_ff;
      query_in       = query_ff;
      next_num_in    = next_num_ff;
      drop_cnt_in    = drop_cnt_ff;
      repl_cnt_in    = repl_cnt_ff;
      me_in          = me_ff;
      me_alive_in    = me_alive_ff;
      killed_in      = killed_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      row_base_in    = row_base_ff;
      sweep_in       = sweep_ff;
      sweep_reply_in = sweep_reply_ff;
      res_status_in  = res_status_ff;
      res_num_in     = res_num_ff;
      res_alive_in   = res_alive_ff;

      cell_we     = 1'b0;
      cell_waddr  = cell_cur;
      cell_wdata  = {1'b1, me_ff};
      cell_raddr  = cell_cur;
      alive_we    = 1'b0;
      alive_waddr = me_ff;
      alive_wdata = 1'b0;
      unbr_we     = 1'b0;
      feat_raddr  = own_idx;

      // CSR writes land in any state.
      if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDE: grid_wide_in = csr_wdata;
            CSR_GRID_HIGH: grid_high_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_SWEEP: begin
            // The cell and alive memories cleared side by side, one entry per cycle.
            cell_waddr  = sweep_ff[CELL_W-1:0];
            cell_wdata  = '0;
            cell_we     = ({1'b0, sweep_ff} < CELL_N_S);
            alive_waddr = sweep_ff[FIDX_W-1:0];
            alive_wdata = 1'b0;
            alive_we    = ({1'b0, sweep_ff} < FEAT_N_S);
            sweep_in    = sweep_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               pos_x_in      = req_ch.pos_x;
               pos_y_in      = req_ch.pos_y;
               foot_wide_in  = req_ch.foot_wide;
               foot_high_in  = req_ch.foot_high;
               unbr_in       = req_ch.unbreakable;
               query_in      = req_ch.query_index;
               killed_in     = '0;
               res_status_in = STATUS_DONE;
               res_num_in    = '0;
               res_alive_in  = 1'b0;
               if (req_ch.mode == MODE_QUERY) begin
                  res_num_in = req_ch.query_index;
               end
               if (req_ch.mode == MODE_CLEAR) begin
                  next_num_in    = '0;
                  drop_cnt_in    = '0;
                  repl_cnt_in    = '0;
                  sweep_in       = '0;
                  sweep_reply_in = 1'b1;
               end
            end
         end
         ST_PLACE_CHECK: begin
            if (table_full) begin
               res_status_in = STATUS_TABLE_FULL;
               drop_cnt_in   = sat_inc(drop_cnt_ff);
            end else begin
               // Number is taken even when the footprint is dropped.
               me_in        = next_num_ff[FIDX_W-1:0];
               next_num_in  = next_num_ff + 1'b1;
               res_num_in   = new_ext[FNUM_W-1:0];
               unbr_we      = 1'b1;
               alive_we     = 1'b1;
               alive_waddr  = next_num_ff[FIDX_W-1:0];
               alive_wdata  = 1'b0;
               if (out_of_bounds) begin
                  res_status_in = STATUS_OUT_BOUNDS;
                  drop_cnt_in   = sat_inc(drop_cnt_ff);
               end else begin
                  row_base_in = row_start[CELL_W-1:0];
                  dx_in       = '0;
                  dy_in       = '0;
                  me_alive_in = 1'b1;
               end
            end
         end
         ST_WALK_READ: begin
            cell_raddr = cell_cur;
         end
         ST_WALK_OWN: begin
            // owner of the current cell is out of memory: look it up
            feat_raddr = own_idx;
         end
         ST_WALK_DECIDE: begin
            cell_raddr = cell_next;
            if (hit_hard) begin
               me_alive_in = 1'b0;
               drop_cnt_in = sat_inc(drop_cnt_ff);
            end else begin
               cell_we    = 1'b1;
               cell_waddr = cell_cur;
               cell_wdata = {1'b1, me_ff};
               if (live_owner) begin
                  alive_we    = 1'b1;
                  alive_waddr = own_idx;
                  alive_wdata = 1'b0;
                  killed_in   = killed_ff + 11'd1;
                  repl_cnt_in = sat_inc(repl_cnt_ff);
               end
               if (dx_last) begin
                  dx_in = '0;
                  if (!dy_last) begin
                     dy_in       = dy_ff + 8'd1;
                     row_base_in = row_base_ff + ROW_STEP;
                  end
               end else begin
                  dx_in = dx_ff + 8'd1;
               end
            end
         end
         ST_PLACE_END: begin
            alive_we      = 1'b1;
            alive_waddr   = me_ff;
            alive_wdata   = me_alive_ff;
            res_status_in = me_alive_ff ? STATUS_PLACED : STATUS_BLOCKED;
            res_alive_in  = me_alive_ff;
            res_num_in    = me_ext[FNUM_W-1:0];
         end
         ST_QUERY_READ: begin
            feat_raddr = query_ext[FIDX_W-1:0];
         end
         ST_QUERY_USE: begin
            // numbers past the table read as dead
            res_alive_in = (query_ext < FEAT_EXT) && alive_rd_ff;
         end
         ST_FINISH: begin
            sweep_reply_in = 1'b0;
         end
         default: ;
      endcase
   end

   // Output register: loads from staging when the slot is free.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_killed_in = rsp_killed_ff;
      rsp_alive_in  = rsp_alive_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_repl_in   = rsp_repl_ff;
      if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_num_in    = res_num_ff;
         rsp_killed_in = killed_ff;
         rsp_alive_in  = res_alive_ff;
         rsp_drop_in   = drop_cnt_ff;
         rsp_repl_in   = repl_cnt_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Clocked state
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         grid_wide_ff   <= '0;
         grid_high_ff   <= '0;
         next_num_ff    <= '0;
         drop_cnt_ff    <= '0;
         repl_cnt_ff    <= '0;
         sweep_ff       <= '0;
         sweep_reply_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         grid_wide_ff   <= grid_wide_in;
         grid_high_ff   <= grid_high_in;
         next_num_ff    <= next_num_in;
         drop_cnt_ff    <= drop_cnt_in;
         repl_cnt_ff    <= repl_cnt_in;
         sweep_ff       <= sweep_in;
         sweep_reply_ff <= sweep_reply_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff      <= pos_x_in;
      pos_y_ff      <= pos_y_in;
      foot_wide_ff  <= foot_wide_in;
      foot_high_ff  <= foot_high_in;
      unbr_ff       <= unbr_in;
      query_ff      <= query_in;
      me_ff         <= me_in;
      me_alive_ff   <= me_alive_in;
      killed_ff     <= killed_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      row_base_ff   <= row_base_in;
      res_status_ff <= res_status_in;
      res_num_ff    <= res_num_in;
      res_alive_ff  <= res_alive_in;
      rsp_status_ff <= rsp_status_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_killed_ff <= rsp_killed_in;
      rsp_alive_ff  <= rsp_alive_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_repl_ff   <= rsp_repl_in;
   end

   // Memories: one write and one registered read per cycle each.
   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      owner_rd_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (alive_we) begin
         alive_mem[alive_waddr] <= alive_wdata;
      end
      alive_rd_ff <= alive_mem[feat_raddr];
   end

   // Unbreakable bits are only read for live owners, which were written at placement.
   always_ff @(posedge clock) begin
      if (unbr_we) begin
         unbr_mem[me_in] <= unbr_ff;
      end
      unbr_rd_ff <= unbr_mem[feat_raddr];
   end

   // ---------------------------------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------------------------------
   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.feature_number = rsp_num_ff;
   assign rsp_ch.replaced_now   = rsp_killed_ff;
   assign rsp_ch.is_alive       = rsp_alive_ff;
   assign rsp_ch.dropped_total  = rsp_drop_ff;
   assign rsp_ch.replaced_total = rsp_repl_ff;

endmodule

`default_nettype wire

[design/fpor_checker.sv]
// Port-level checker for the footprint overlap resolver core, with its bind.
// Depends on fpor_pkg and footprint_overlap_resolver_core_assert.svh.
`default_nettype none

`include "footprint_overlap_resolver_core_assert.svh"

module fpor_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [fpor_pkg::STATUS_W-1:0]     rsp_status,
   input wire logic [fpor_pkg::FNUM_W-1:0]       rsp_feature_number,
   input wire logic [fpor_pkg::COUNT_W-1:0]      rsp_replaced_now,
   input wire logic                              rsp_is_alive,
   input wire logic [fpor_pkg::COUNT_W-1:0]      rsp_dropped_total,
   input wire logic [fpor_pkg::COUNT_W-1:0]      rsp_replaced_total
);
   import fpor_pkg::*;

   // reset always starts the memory sweep, so no word is taken right after it
   `FPOR_ASSERT_NORST(a_sweep_after_reset, clock, reset |=> !req_ready, "ready after reset")

   `FPOR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_feature_number), "stalled word changed")

   `FPOR_ASSERT(a_placed_alive, clock, reset, rsp_valid && (rsp_status == STATUS_PLACED || rsp_status == STATUS_OUT_BOUNDS || rsp_status == STATUS_BLOCKED || rsp_status == STATUS_TABLE_FULL) |-> rsp_is_alive == (rsp_status == STATUS_PLACED), "alive bit disagrees with status")

   `FPOR_ASSERT(a_kills_only_walked, clock, reset, rsp_valid && rsp_status != STATUS_PLACED && rsp_status != STATUS_BLOCKED |-> rsp_replaced_now == '0, "kills without a walk")

   `FPOR_ASSERT(a_totals_saturate, clock, reset, rsp_valid |-> rsp_dropped_total <= COUNT_LIMIT && rsp_replaced_total <= COUNT_LIMIT, "total past limit")

endmodule

bind footprint_overlap_resolver_core fpor_checker u_fpor_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_feature_number (rsp_ch.feature_number),
   .rsp_replaced_now   (rsp_ch.replaced_now),
   .rsp_is_alive       (rsp_ch.is_alive),
   .rsp_dropped_total  (rsp_ch.dropped_total),
   .rsp_replaced_total (rsp_ch.replaced_total)
);

`default_nettype wire

[tb/sv/footprint_overlap_resolver_core_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for footprint_overlap_resolver_core: random and directed request words
// checked against an in-bench predictor of the grid, feature table and counters.
// Depends on fpor_pkg, fpor_if and the core itself.

module footprint_overlap_resolver_core_test;
   import fpor_pkg::*;

   localparam int GRID_SIDE  = 256;
   localparam int MAX_FEAT   = 1024;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;

   // Mode 3 has no function; the core must answer it and change nothing.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [FOOT_W-1:0]   foot_wide;
      logic [FOOT_W-1:0]   foot_high;
      logic                unbreakable;
      logic [QIDX_W-1:0]   query_index;
   } req_word_t;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FNUM_W-1:0]   feature_number;
      logic [COUNT_W-1:0]  replaced_now;
      logic                is_alive;
      logic [COUNT_W-1:0]  dropped_total;
      logic [COUNT_W-1:0]  replaced_total;
   } rsp_word_t;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [GRID_REG_W-1:0]  csr_wdata;

   fpor_req_if req_ch();
   fpor_rsp_if rsp_ch();

   footprint_overlap_resolver_core #(
      .GRID_SIDE    (GRID_SIDE),
      .MAX_FEATURES (MAX_FEAT)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: owner of each grid cell, per-feature live and
   // unbreakable flags, the numbering counter and the two running totals.
   // ------------------------------------------------------------------
   logic [FNUM_W-1:0] claim_owner [GRID_CELLS];
   bit                claim_set   [GRID_CELLS];
   bit                live_flag   [MAX_FEAT];
   bit                hard_flag   [MAX_FEAT];
   int unsigned       issue_count;
   int unsigned       drop_tally;
   int unsigned       kill_tally;
   int unsigned       grid_w_reg;
   int unsigned       grid_h_reg;

   rsp_word_t         awaited_results [$];
   int unsigned       fail_count;
   bit                steady_flow;   // both sides run without idle cycles while set

   function automatic void wipe_model();
      foreach (claim_set[i]) begin
         claim_set[i]   = 1'b0;
         claim_owner[i] = '0;
      end
      foreach (live_flag[i]) begin
         live_flag[i] = 1'b0;
         hard_flag[i] = 1'b0;
      end
      issue_count = 0;
      drop_tally  = 0;
      kill_tally  = 0;
   endfunction

   function automatic int unsigned bump(int unsigned v);
      return (v + 1 > COUNT_LIMIT) ? COUNT_LIMIT : v + 1;
   endfunction

   // Register values above the grid side behave as the full side.
   function automatic int clamp_grid(int unsigned v);
      return (v > GRID_SIDE) ? GRID_SIDE : int'(v);
   endfunction

   function automatic bit fits_grid(req_word_t w);
      int x, y, fw, fh;
      x  = $signed(w.pos_x);
      y  = $signed(w.pos_y);
      fw = w.foot_wide;
      fh = w.foot_high;
      return x >= 0 && y >= 0 && fw > 0 && fh > 0 &&
             x + fw <= clamp_grid(grid_w_reg) && y + fh <= clamp_grid(grid_h_reg);
   endfunction

   // Expected response for one accepted word; updates the predictor state.
   function automatic rsp_word_t resolve_word(req_word_t w);
      rsp_word_t   r;
      int          x, y, fw, fh, dx, dy, spot;
      int unsigned me, prior, killed;
      bit          halted;
      r        = '0;
      r.status = STATUS_DONE;
      killed   = 0;
      case (w.mode)
         MODE_PLACE: begin
            if (issue_count >= MAX_FEAT) begin
               // table full: nothing but the drop count moves
               r.status   = STATUS_TABLE_FULL;
               drop_tally = bump(drop_tally);
            end else begin
               // the number is spent even if the word is dropped
               me               = issue_count;
               issue_count      = issue_count + 1;
               r.feature_number = me[FNUM_W-1:0];
               hard_flag[me]    = w.unbreakable;
               live_flag[me]    = 1'b0;
               if (!fits_grid(w)) begin
                  r.status   = STATUS_OUT_BOUNDS;
                  drop_tally = bump(drop_tally);
               end else begin
                  x  = $signed(w.pos_x);
                  y  = $signed(w.pos_y);
                  fw = w.foot_wide;
                  fh = w.foot_high;
                  live_flag[me] = 1'b1;
                  halted        = 1'b0;
                  // row-major walk; a live unbreakable owner stops it, earlier claims stay
                  for (dy = 0; dy < fh && !halted; dy++) begin
                     for (dx = 0; dx < fw && !halted; dx++) begin
                        spot  = (y + dy) * GRID_SIDE + x + dx;
                        prior = claim_owner[spot];
                        if (claim_set[spot] && prior != me && live_flag[prior]) begin
                           if (hard_flag[prior]) begin
                              halted        = 1'b1;
                              live_flag[me] = 1'b0;
                              drop_tally    = bump(drop_tally);
                           end else begin
                              live_flag[prior] = 1'b0;
                              killed           = killed + 1;
                              kill_tally       = bump(kill_tally);
                           end
                        end
                        if (!halted) begin
                           claim_set[spot]   = 1'b1;
                           claim_owner[spot] = me[FNUM_W-1:0];
                        end
                     end
                  end
                  r.status   = halted ? STATUS_BLOCKED : STATUS_PLACED;
                  r.is_alive = !halted;
               end
            end
         end
         MODE_QUERY: begin
            r.feature_number = w.query_index;
            r.is_alive       = live_flag[w.query_index];
         end
         MODE_CLEAR: wipe_model();
         default: ;
      endcase
      r.replaced_now   = killed[COUNT_W-1:0];
      r.dropped_total  = drop_tally[COUNT_W-1:0];
      r.replaced_total = kill_tally[COUNT_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Word builders
   // ------------------------------------------------------------------
   function automatic int draw_idle();
      return steady_flow ? 0 : int'($urandom_range(0, 17));
   endfunction

   // every field random, so bits that a mode ignores still toggle
   function automatic req_word_t scramble_word();
      req_word_t w;
      w.mode        = MODE_W'($urandom_range(0, 3));
      w.pos_x       = POS_W'($urandom);
      w.pos_y       = POS_W'($urandom);
      w.foot_wide   = FOOT_W'($urandom);
      w.foot_high   = FOOT_W'($urandom);
      w.unbreakable = 1'($urandom);
      w.query_index = QIDX_W'($urandom);
      return w;
   endfunction

   function automatic req_word_t place_at(int x, int y, int fw, int fh, bit hard);
      req_word_t w;
      w             = scramble_word();
      w.mode        = MODE_PLACE;
      w.pos_x       = POS_W'(x);
      w.pos_y       = POS_W'(y);
      w.foot_wide   = FOOT_W'(fw);
      w.foot_high   = FOOT_W'(fh);
      w.unbreakable = hard;
      return w;
   endfunction

   function automatic req_word_t query_word(int unsigned idx);
      req_word_t w;
      w             = scramble_word();
      w.mode        = MODE_QUERY;
      w.query_index = QIDX_W'(idx);
      return w;
   endfunction

   function automatic req_word_t mode_word(logic [MODE_W-1:0] m);
      req_word_t w;
      w      = scramble_word();
      w.mode = m;
      return w;
   endfunction

   // Place with a negative column, always dropped.
   function automatic req_word_t negative_place();
      req_word_t w;
      w                = scramble_word();
      w.mode           = MODE_PLACE;
      w.pos_x[POS_W-1] = 1'b1;
      return w;
   endfunction

   // Random mix: mostly in-bounds places with small footprints near the origin
   // so that they overlap, plus queries, malformed places and the unused mode.
   function automatic req_word_t random_word();
      req_word_t   w;
      int          gw, gh, lim, win, fw, fh;
      int unsigned pick, back;
      w    = scramble_word();
      pick = $urandom_range(0, 99);
      gw   = clamp_grid(grid_w_reg);
      gh   = clamp_grid(grid_h_reg);
      if (pick < 3) begin
         w.mode = MODE_UNUSED;
      end else if (pick < 15) begin
         w.mode = MODE_QUERY;
         if (issue_count > 0 && $urandom_range(0, 2) != 0) begin
            back          = (issue_count - 1 < 40) ? issue_count - 1 : 40;
            w.query_index = QIDX_W'(issue_count - 1 - $urandom_range(0, back));
         end
      end else if (pick < 25 || gw == 0 || gh == 0) begin
         // malformed or far away; keep any accidental fit cheap to walk
         w.mode = MODE_PLACE;
         if (fits_grid(w) && w.foot_wide * w.foot_high > 64)
            w.foot_wide = '0;
      end else begin
         lim = ($urandom_range(0, 7) == 0) ? 16 : 4;
         fw  = $urandom_range(1, (gw < lim) ? gw : lim);
         fh  = $urandom_range(1, (gh < lim) ? gh : lim);
         win = ($urandom_range(0, 3) == 0) ? GRID_SIDE : 20;
         w   = place_at($urandom_range(0, (gw - fw < win) ? gw - fw : win),
                        $urandom_range(0, (gh - fh < win) ? gh - fh : win),
                        fw, fh, $urandom_range(0, 9) == 0);
      end
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Request side. Valid stays high from one word to the next when no idle
   // cycles are drawn, so it is never dropped and raised in one step.
   // ------------------------------------------------------------------
   task automatic push_word(input req_word_t w);
      int gap;
      gap = draw_idle();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= w.mode;
      req_ch.pos_x       <= w.pos_x;
      req_ch.pos_y       <= w.pos_y;
      req_ch.foot_wide   <= w.foot_wide;
      req_ch.foot_high   <= w.foot_high;
      req_ch.unbreakable <= w.unbreakable;
      req_ch.query_index <= w.query_index;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      awaited_results = {awaited_results, resolve_word(w)};
   endtask

   // Hold the request side until every response is back, then let the core settle.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (awaited_results.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_grid(int unsigned wide, int unsigned high);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_GRID_WIDE;
      csr_wdata <= wide[GRID_REG_W-1:0];
      @(posedge clock);
      csr_index <= CSR_GRID_HIGH;
      csr_wdata <= high[GRID_REG_W-1:0];
      @(posedge clock);
      csr_we     <= 1'b0;
      grid_w_reg  = wide & 9'h1FF;
      grid_h_reg  = high & 9'h1FF;
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall before each word, check against the oldest
   // expectation.
   // ------------------------------------------------------------------
   int sink_wait;

   task automatic check_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : result_monitor
      rsp_word_t want;
      int        stall;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_wait    <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_results.size() == 0) begin
            $error("response word with no request outstanding");
            fail_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("status", want.status, rsp_ch.status);
            check_field("feature_number", want.feature_number, rsp_ch.feature_number);
            check_field("replaced_now", want.replaced_now, rsp_ch.replaced_now);
            check_field("is_alive", want.is_alive, rsp_ch.is_alive);
            check_field("dropped_total", want.dropped_total, rsp_ch.dropped_total);
            check_field("replaced_total", want.replaced_total, rsp_ch.replaced_total);
         end
         stall         = draw_idle();
         sink_wait    <= stall;
         rsp_ch.ready <= (stall == 0);
      end else if (sink_wait > 0) begin
         sink_wait    <= sink_wait - 1;
         rsp_ch.ready <= (sink_wait == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Zero-size grid: every place is out of bounds; query and unused mode still answer.
   task automatic test_empty_grid();
      write_grid(0, 0);
      push_word(place_at(0, 0, 1, 1, 1'b0));
      push_word(query_word(0));
      push_word(mode_word(MODE_UNUSED));
   endtask

   // Edges of the 256x256 grid and malformed rectangles.
   task automatic test_bounds();
      write_grid(256, 256);
      push_word(place_at(0, 0, 1, 1, 1'b0));
      push_word(place_at(255, 255, 1, 1, 1'b0));
      push_word(place_at(255, 0, 2, 1, 1'b0));     // one column past the edge
      push_word(place_at(-32768, 0, 1, 1, 1'b0));
      push_word(place_at(0, 32767, 1, 1, 1'b0));
      push_word(place_at(-1, -1, 4, 4, 1'b1));
      push_word(place_at(3, 3, 0, 2, 1'b0));       // zero width
      push_word(place_at(3, 3, 2, 0, 1'b0));       // zero height
   endtask

   // Blocking by an unbreakable owner, partial claims, replacement of breakable owners.
   task automatic test_overlap();
      push_word(place_at(10, 10, 4, 4, 1'b1));
      push_word(place_at(8, 12, 6, 2, 1'b0));      // claims two cells, then blocked
      push_word(place_at(20, 20, 3, 3, 1'b0));
      push_word(place_at(21, 21, 3, 3, 1'b0));     // replaces one
      push_word(place_at(19, 19, 6, 6, 1'b0));     // replaces the survivor only
      push_word(place_at(8, 12, 2, 1, 1'b1));      // lands on the dead feature's claims
      push_word(query_word(issue_count - 2));
      push_word(query_word(issue_count - 4));
      push_word(place_at(9, 12, 1, 1, 1'b0));      // blocked at once
   endtask

   // Largest footprints, a 255x255 walk, the top feature index, clear.
   task automatic test_wide_footprint();
      push_word(place_at(0, 0, 255, 255, 1'b0));   // kills rows 0..9, blocked in row 10
      push_word(mode_word(MODE_CLEAR));
      push_word(place_at(0, 0, 255, 255, 1'b1));   // whole walk on an empty grid
      push_word(place_at(255, 255, 1, 1, 1'b0));
      push_word(place_at(254, 254, 1, 1, 1'b0));
      push_word(query_word(1023));
      push_word(query_word(0));
      push_word(mode_word(MODE_UNUSED));
      push_word(mode_word(MODE_CLEAR));
   endtask

   task automatic run_random(int unsigned wide, int unsigned high, int count);
      write_grid(wide, high);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0)
            steady_flow = ($urandom_range(0, 3) == 0);
         push_word(random_word());
      end
      steady_flow = 1'b0;
   endtask

   // Dropped places until the numbers run out and the drop total pins at its limit.
   task automatic test_drop_saturation();
      while (drop_tally < COUNT_LIMIT) begin
         push_word(negative_place());
      end
      repeat (8) push_word(negative_place());
      push_word(mode_word(MODE_CLEAR));
   endtask

   initial begin
      fail_count  = 0;
      steady_flow = 1'b0;
      grid_w_reg  = 0;
      grid_h_reg  = 0;
      wipe_model();
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_GRID_WIDE;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= MODE_PLACE;
      req_ch.pos_x       <= '0;
      req_ch.pos_y       <= '0;
      req_ch.foot_wide   <= '0;
      req_ch.foot_high   <= '0;
      req_ch.unbreakable <= 1'b0;
      req_ch.query_index <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_grid();
      test_bounds();
      test_overlap();
      test_wide_footprint();
      run_random(16, 16, 220);
      run_random(256, 256, 220);
      run_random(40, 8, 220);
      test_drop_saturation();
      run_random(511, 300, 200);   // both registers above the grid side
      run_random(1, 256, 75);
      run_random(256, 1, 75);

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Covers the reset sweep, three grid clears, one 255x255 walk and worst-case stalls.
   initial begin
      #96_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/fpor_pkg.sv
design/fpor_if.sv
design/footprint_overlap_resolver_core.sv
design/fpor_checker.sv
tb/sv/footprint_overlap_resolver_core_test.sv
